[rtl/yla_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yla_pkg
// Shared constants, register codes and coefficient helper for the luma
// adjust / greyscale pipeline.
// ----------------------------------------------------------------------------
package yla_pkg;

    // default number of fraction bits in the fixed-point datapath
    localparam int FRAC_BITS_DEF = 14;

    // pixel channel and stream widths
    localparam int PIX_W  = 8;
    localparam int DATA_W = 3 * PIX_W;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 1'b1;

    // mode codes
    localparam logic MODE_BRIGHT = 1'b0;
    localparam logic MODE_GREY   = 1'b1;

    // reset values
    localparam logic signed [CFG_DATA_W-1:0] OFFSET_RST = -9'sd100;

    // coefficient in thousandths scaled by 2^fb, exact halves rounded up
    function automatic longint coef(input longint milli, input int fb);
        longint scaled;
        scaled = milli * (longint'(1) << fb);
        return (scaled + 500) / 1000;
    endfunction

endpackage
`default_nettype wire

[rtl/yla_fwd.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yla_fwd
// Forward RGB to YUV conversion in two register stages: coefficient
// products, then the three sums with the luma offset and mode applied.
// ----------------------------------------------------------------------------
module yla_fwd
    import yla_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire                                      i_valid,
    output logic                                     o_ready,
    input  wire  [PIX_W-1:0]                         i_red,
    input  wire  [PIX_W-1:0]                         i_green,
    input  wire  [PIX_W-1:0]                         i_blue,
    input  wire                                      i_mode,
    input  wire  signed [CFG_DATA_W-1:0]             i_offset,
    output logic                                     o_valid,
    input  wire                                      i_ready,
    output logic signed [FRAC_BITS+10:0]             o_y,
    output logic signed [FRAC_BITS+10:0]             o_u,
    output logic signed [FRAC_BITS+10:0]             o_v
);

    localparam int CW = FRAC_BITS + 2;
    localparam int PW = FRAC_BITS + 10;
    localparam int YW = FRAC_BITS + 11;

    localparam logic [CW-1:0] C_YR = CW'(coef(299, FRAC_BITS));
    localparam logic [CW-1:0] C_YG = CW'(coef(587, FRAC_BITS));
    localparam logic [CW-1:0] C_YB = CW'(coef(114, FRAC_BITS));
    localparam logic [CW-1:0] C_UR = CW'(coef(147, FRAC_BITS));
    localparam logic [CW-1:0] C_UG = CW'(coef(289, FRAC_BITS));
    localparam logic [CW-1:0] C_UB = CW'(coef(436, FRAC_BITS));
    localparam logic [CW-1:0] C_VR = CW'(coef(615, FRAC_BITS));
    localparam logic [CW-1:0] C_VG = CW'(coef(515, FRAC_BITS));
    localparam logic [CW-1:0] C_VB = CW'(coef(100, FRAC_BITS));

    logic          r_v1;
    logic          r_v2;
    logic          adv1;
    logic          adv2;

    logic [PW-1:0] r_p_yr, r_p_yg, r_p_yb;
    logic [PW-1:0] r_p_ur, r_p_ug, r_p_ub;
    logic [PW-1:0] r_p_vr, r_p_vg, r_p_vb;

    logic signed [YW-1:0] n_y, n_u, n_v;
    logic signed [YW-1:0] r_y, r_u, r_v;
    logic signed [YW-1:0] off_fx;

    // stage advance, bubbles are filled while the far side stalls
    assign adv2    = !r_v2 || i_ready;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;
    assign o_valid = r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // stage 1: coefficient times channel, all unsigned
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_p_yr <= PW'(C_YR) * PW'(i_red);
            r_p_yg <= PW'(C_YG) * PW'(i_green);
            r_p_yb <= PW'(C_YB) * PW'(i_blue);
            r_p_ur <= PW'(C_UR) * PW'(i_red);
            r_p_ug <= PW'(C_UG) * PW'(i_green);
            r_p_ub <= PW'(C_UB) * PW'(i_blue);
            r_p_vr <= PW'(C_VR) * PW'(i_red);
            r_p_vg <= PW'(C_VG) * PW'(i_green);
            r_p_vb <= PW'(C_VB) * PW'(i_blue);
        end
    end

    // luma offset aligned to the fraction point
    assign off_fx = {{2{i_offset[CFG_DATA_W-1]}}, i_offset, {FRAC_BITS{1'b0}}};

    // stage 2: signed sums, greyscale drops chroma and offset
    always_comb begin
        n_y = $signed(YW'(r_p_yr)) + $signed(YW'(r_p_yg)) + $signed(YW'(r_p_yb));
        n_u = $signed(YW'(r_p_ub)) - $signed(YW'(r_p_ur)) - $signed(YW'(r_p_ug));
        n_v = $signed(YW'(r_p_vr)) - $signed(YW'(r_p_vg)) - $signed(YW'(r_p_vb));
        if (i_mode == MODE_GREY) begin
            n_u = '0;
            n_v = '0;
        end else begin
            n_y = n_y + off_fx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_y <= n_y;
            r_u <= n_u;
            r_v <= n_v;
        end
    end

    assign o_y = r_y;
    assign o_u = r_u;
    assign o_v = r_v;

endmodule
`default_nettype wire

[rtl/yla_inv.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yla_inv
// Chroma part of the inverse conversion in two register stages: signed
// chroma products, then per-channel sums floored back to the fraction point.
// ----------------------------------------------------------------------------
module yla_inv
    import yla_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire                                      i_valid,
    output logic                                     o_ready,
    input  wire  signed [FRAC_BITS+10:0]             i_y,
    input  wire  signed [FRAC_BITS+10:0]             i_u,
    input  wire  signed [FRAC_BITS+10:0]             i_v,
    output logic                                     o_valid,
    input  wire                                      i_ready,
    output logic signed [FRAC_BITS+10:0]             o_y,
    output logic signed [FRAC_BITS+14:0]             o_cr,
    output logic signed [FRAC_BITS+14:0]             o_cg,
    output logic signed [FRAC_BITS+14:0]             o_cb
);

    localparam int CW = FRAC_BITS + 2;
    localparam int YW = FRAC_BITS + 11;
    localparam int MW = YW + CW + 1;
    localparam int SW = MW + 1 - FRAC_BITS;

    localparam logic signed [CW:0] C_RV = {1'b0, CW'(coef(1140, FRAC_BITS))};
    localparam logic signed [CW:0] C_GU = {1'b0, CW'(coef(395, FRAC_BITS))};
    localparam logic signed [CW:0] C_GV = {1'b0, CW'(coef(580, FRAC_BITS))};
    localparam logic signed [CW:0] C_BU = {1'b0, CW'(coef(2036, FRAC_BITS))};

    logic                 r_v3;
    logic                 r_v4;
    logic                 adv3;
    logic                 adv4;

    logic signed [YW-1:0] r_y3;
    logic signed [YW-1:0] r_y4;
    logic signed [MW-1:0] r_prv, r_pgu, r_pgv, r_pbu;
    logic signed [MW:0]   n_gsum;
    logic signed [SW-1:0] r_cr, r_cg, r_cb;

    assign adv4    = !r_v4 || i_ready;
    assign adv3    = !r_v3 || adv4;
    assign o_ready = adv3;
    assign o_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv3) begin
                r_v3 <= i_valid;
            end
            if (adv4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // stage 3: chroma products carrying twice the fraction bits
    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_y3  <= i_y;
            r_prv <= MW'(i_v) * MW'(C_RV);
            r_pgu <= MW'(i_u) * MW'(C_GU);
            r_pgv <= MW'(i_v) * MW'(C_GV);
            r_pbu <= MW'(i_u) * MW'(C_BU);
        end
    end

    // green takes both negated terms before the floor
    assign n_gsum = -(MW+1)'(r_pgu) - (MW+1)'(r_pgv);

    // stage 4: arithmetic shift gives the floor towards minus infinity
    always_ff @(posedge i_clk) begin
        if (adv4) begin
            r_y4 <= r_y3;
            r_cr <= SW'(r_prv >>> FRAC_BITS);
            r_cg <= SW'(n_gsum >>> FRAC_BITS);
            r_cb <= SW'(r_pbu >>> FRAC_BITS);
        end
    end

    assign o_y  = r_y4;
    assign o_cr = r_cr;
    assign o_cg = r_cg;
    assign o_cb = r_cb;

endmodule
`default_nettype wire

[rtl/yla_clamp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yla_clamp
// Adds luma to each chroma term, clamps to 0..255 and drops the fraction,
// into the output register that faces the result stream.
// ----------------------------------------------------------------------------
module yla_clamp
    import yla_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire                                      i_valid,
    output logic                                     o_ready,
    input  wire  signed [FRAC_BITS+10:0]             i_y,
    input  wire  signed [FRAC_BITS+14:0]             i_cr,
    input  wire  signed [FRAC_BITS+14:0]             i_cg,
    input  wire  signed [FRAC_BITS+14:0]             i_cb,
    output logic                                     o_valid,
    input  wire                                      i_ready,
    output logic [DATA_W-1:0]                        o_data
);

    localparam int YW = FRAC_BITS + 11;
    localparam int SW = FRAC_BITS + 15;
    localparam int TW = SW + 1;

    localparam logic signed [TW-1:0] C_MAX = TW'(255) <<< FRAC_BITS;

    logic              r_v5;
    logic              adv5;
    logic [PIX_W-1:0]  n_red, n_green, n_blue;
    logic [DATA_W-1:0] r_data;

    // clamp one channel and keep its integer part
    function automatic logic [PIX_W-1:0] sat(input logic signed [YW-1:0] y,
                                             input logic signed [SW-1:0] c);
        logic signed [TW-1:0] t;
        t = TW'(y) + TW'(c);
        if (t[TW-1]) begin
            return '0;
        end else if (t > C_MAX) begin
            return '1;
        end else begin
            return t[FRAC_BITS +: PIX_W];
        end
    endfunction

    assign n_red   = sat(i_y, i_cr);
    assign n_green = sat(i_y, i_cg);
    assign n_blue  = sat(i_y, i_cb);

    assign adv5    = !r_v5 || i_ready;
    assign o_ready = adv5;
    assign o_valid = r_v5;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (adv5) begin
            r_v5 <= i_valid;
        end
    end

    // stage 5: output register, red in the lowest byte
    always_ff @(posedge i_clk) begin
        if (adv5) begin
            r_data <= {n_blue, n_green, n_red};
        end
    end

endmodule
`default_nettype wire

[rtl/yuv_luma_adjust_or_greyscale_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yuv_luma_adjust_or_greyscale_top
// RGB pixel stream through YUV and back, with a luma offset or greyscale.
// ----------------------------------------------------------------------------
// Each RGB item is converted to YUV in fixed point with FRAC_BITS fraction
// bits, then either has the signed luma offset added (mode 0) or has its
// chroma dropped (mode 1, greyscale), and is converted back to RGB with every
// channel clamped to 0..255. The block takes one item per clock while the
// output is not stalled. Each result passes through two stages of forward
// conversion (products, sums), two of chroma inversion (products, floored
// sums) and the clamp stage that is the output register. A stalled output
// holds the pipeline stage by stage, so bubbles are still squeezed out while
// waiting. Configuration writes are always ready; write them only while no
// item is in flight.
// ----------------------------------------------------------------------------
module yuv_luma_adjust_or_greyscale_top
    import yla_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // pixel in
    input  wire                     i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  wire  [DATA_W-1:0]       i_s_axis_tdata,  // in_red, in_green, in_blue
    // pixel out
    output logic                    o_m_axis_tvalid,
    input  wire                     i_m_axis_tready,
    output logic [DATA_W-1:0]       o_m_axis_tdata,  // out_red, out_green, out_blue
    // configuration writes
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int YW = FRAC_BITS + 11;
    localparam int SW = FRAC_BITS + 15;

    logic                         r_mode;
    logic signed [CFG_DATA_W-1:0] r_offset;

    logic                 fwd_valid, fwd_ready;
    logic signed [YW-1:0] fwd_y, fwd_u, fwd_v;
    logic                 inv_valid, inv_ready;
    logic signed [YW-1:0] inv_y;
    logic signed [SW-1:0] inv_cr, inv_cg, inv_cb;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_BRIGHT;
            r_offset <= OFFSET_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MODE:   r_mode   <= i_cfg_data[0];
                REG_OFFSET: r_offset <= $signed(i_cfg_data);
                default:    ;
            endcase
        end
    end

    yla_fwd #(
        .FRAC_BITS (FRAC_BITS)
    ) u_fwd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_red    (i_s_axis_tdata[0*PIX_W +: PIX_W]),
        .i_green  (i_s_axis_tdata[1*PIX_W +: PIX_W]),
        .i_blue   (i_s_axis_tdata[2*PIX_W +: PIX_W]),
        .i_mode   (r_mode),
        .i_offset (r_offset),
        .o_valid  (fwd_valid),
        .i_ready  (fwd_ready),
        .o_y      (fwd_y),
        .o_u      (fwd_u),
        .o_v      (fwd_v)
    );

    yla_inv #(
        .FRAC_BITS (FRAC_BITS)
    ) u_inv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fwd_valid),
        .o_ready (fwd_ready),
        .i_y     (fwd_y),
        .i_u     (fwd_u),
        .i_v     (fwd_v),
        .o_valid (inv_valid),
        .i_ready (inv_ready),
        .o_y     (inv_y),
        .o_cr    (inv_cr),
        .o_cg    (inv_cg),
        .o_cb    (inv_cb)
    );

    yla_clamp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_clamp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (inv_valid),
        .o_ready (inv_ready),
        .i_y     (inv_y),
        .i_cr    (inv_cr),
        .i_cg    (inv_cg),
        .i_cb    (inv_cb),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

endmodule
`default_nettype wire
